>>> rtl/fit_policy_block_allocator_top_defines.svh
// Assertion macros used by the checker file of the fit-policy block allocator.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Concurrent property check on clk, disabled while rst_n is low.
`define FPBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that expr holds in the cycle after cond.
`define FPBA_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/fpba_pkg.sv
// Package with the types, codes and defaults of the fit-policy block allocator.
`timescale 1ns / 1ps

package fpba_pkg;

    localparam int BLOCKS_DEF    = 8;
    localparam int SIZE_BITS_DEF = 16;

    // Item kinds.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Placement policies; the unused code behaves as first fit.
    localparam logic [1:0] FIT_FIRST    = 2'd0;
    localparam logic [1:0] FIT_BEST     = 2'd1;
    localparam logic [1:0] FIT_WORST    = 2'd2;
    localparam logic [1:0] FIT_RESERVED = 2'd3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_FIT_MODE      = 1'b0;
    localparam logic REG_ACTIVE_BLOCKS = 1'b1;

    localparam logic [1:0] FIT_MODE_RST      = FIT_FIRST;
    localparam logic [3:0] ACTIVE_BLOCKS_RST = 4'd8;

    typedef struct packed {
        logic        op;
        logic [2:0]  block_slot;
        logic [15:0] amount;
    } req_item_t;

    typedef struct packed {
        logic        granted;
        logic [2:0]  chosen_block;
        logic [15:0] left_over;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch the request, clear the search result
        logic ld_we;     // write a loaded size into the table
        logic rd_en;     // read the table entry at the scan index
        logic wb_we;     // write back the reduced size of the chosen entry
        logic res_load;  // load the result register
        logic res_alloc; // result belongs to an allocate transaction
    } fpba_cmd_t;

    typedef struct packed {
        logic found;     // some scanned entry can hold the request
    } fpba_status_t;

endpackage

>>> rtl/fit_policy_block_allocator_top.sv
// Top level of the fit-policy block allocator: configuration registers and the two halves.
//
//   Channel   Handshake             Payload                       Direction
//   req       req_valid/req_stall   req_item (op, slot, amount)   into the block
//   rsp       rsp_valid/rsp_stall   rsp_item (granted, block, left) out of the block
//   cfg       APB psel/penable      paddr/pwdata/prdata           register access
//
// A load transaction's result appears in the cycle after the load is accepted.
// An allocate transaction steps through SCAN, LAST and WRITE, reading one table entry per cycle
// in SCAN for L = active_blocks clipped to BLOCKS (SCAN and LAST are skipped when L is zero).
// Reset clears the control state and the registers; the size table is undefined until loaded.
// A stalled result waits in the output register; a load is held off while a search runs or
// while it would overwrite a result that is still stalled.
`timescale 1ns / 1ps

module fit_policy_block_allocator_top #(
    parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
    parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fpba_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output fpba_pkg::rsp_item_t rsp_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    logic [1:0]             fit_mode_reg;
    logic [3:0]             active_blocks_reg;
    logic                   cfg_we;
    fpba_pkg::fpba_cmd_t    cmd;
    fpba_pkg::fpba_status_t status;
    logic [IDX_W-1:0]       scan_idx;

    // The register index is taken from paddr[2]; the low address bits are ignored.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg      <= fpba_pkg::FIT_MODE_RST;
            active_blocks_reg <= fpba_pkg::ACTIVE_BLOCKS_RST;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == fpba_pkg::REG_FIT_MODE)
            begin
                fit_mode_reg <= pwdata[1:0];
            end
            else
            begin
                active_blocks_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == fpba_pkg::REG_ACTIVE_BLOCKS)
        begin
            prdata = {28'd0, active_blocks_reg};
        end
        else
        begin
            prdata = {30'd0, fit_mode_reg};
        end
    end

    // The controller sequences the scan; the datapath holds the table and ranks entries.
    fpba_ctrl #(
        .BLOCKS (BLOCKS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_op        (req_item.op),
        .req_stall     (req_stall),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .active_blocks (active_blocks_reg),
        .status        (status),
        .cmd           (cmd),
        .scan_idx      (scan_idx)
    );

    fpba_dp #(
        .BLOCKS    (BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .scan_idx (scan_idx),
        .req_item (req_item),
        .fit_mode (fit_mode_reg),
        .status   (status),
        .rsp_item (rsp_item)
    );

endmodule

>>> rtl/fpba_dp.sv
// Datapath of the fit-policy block allocator: size table, search registers, result register.
`timescale 1ns / 1ps

module fpba_dp #(
    parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
    parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fpba_pkg::fpba_cmd_t                     cmd,
    input  logic [((BLOCKS > 1) ? $clog2(BLOCKS) : 1)-1:0] scan_idx,
    input  fpba_pkg::req_item_t                     req_item,
    input  logic [1:0]                              fit_mode,
    output fpba_pkg::fpba_status_t                  status,
    output fpba_pkg::rsp_item_t                     rsp_item
);

    localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int AMT_W  = (SIZE_BITS > 16) ? SIZE_BITS : 16;
    localparam int SLOT_W = (IDX_W > 3) ? IDX_W : 3;
    localparam int CHO_W  = (IDX_W > 3) ? IDX_W : 3;

    logic [SIZE_BITS-1:0] mem [BLOCKS];

    logic [SIZE_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_vld_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     pick_idx_reg;
    logic [IDX_W-1:0]     pick_idx_next;
    logic [SIZE_BITS-1:0] pick_size_reg;
    logic [SIZE_BITS-1:0] pick_size_next;
    fpba_pkg::rsp_item_t  rsp_reg;

    logic [AMT_W-1:0]     amt_ext;
    logic [SIZE_BITS-1:0] amt_in;
    logic [SLOT_W-1:0]    slot_ext;
    logic                 slot_ok;
    logic [SIZE_BITS-1:0] remain;
    logic [AMT_W-1:0]     remain_ext;
    logic [CHO_W-1:0]     pick_ext;
    logic                 fits;
    logic                 take;
    logic                 we;
    logic [IDX_W-1:0]     wa;
    logic [SIZE_BITS-1:0] wd;

    assign amt_ext    = AMT_W'(req_item.amount);
    assign amt_in     = amt_ext[SIZE_BITS-1:0];
    assign slot_ext   = SLOT_W'(req_item.block_slot);
    assign slot_ok    = (32'(req_item.block_slot) < BLOCKS);
    assign remain     = pick_size_reg - req_reg;
    assign remain_ext = AMT_W'(remain);
    assign pick_ext   = CHO_W'(pick_idx_reg);

    // Ties keep the lower index because only a strictly better entry replaces the pick.
    always_comb
    begin
        fits = (rd_data_reg >= req_reg);
        case (fit_mode)
            fpba_pkg::FIT_BEST:  take = fits && (!found_reg || (rd_data_reg < pick_size_reg));
            fpba_pkg::FIT_WORST: take = fits && (!found_reg || (rd_data_reg > pick_size_reg));
            default:             take = fits && !found_reg;
        endcase
    end

    always_comb
    begin
        found_next     = found_reg;
        pick_idx_next  = pick_idx_reg;
        pick_size_next = pick_size_reg;
        if (cmd.start)
        begin
            found_next = 1'b0;
        end
        else if (rd_vld_reg && take)
        begin
            found_next     = 1'b1;
            pick_idx_next  = rd_idx_reg;
            pick_size_next = rd_data_reg;
        end
    end

    always_comb
    begin
        we = 1'b0;
        wa = pick_idx_reg;
        wd = remain;
        if (cmd.ld_we && slot_ok)
        begin
            we = 1'b1;
            wa = slot_ext[IDX_W-1:0];
            wd = amt_in;
        end
        else if (cmd.wb_we)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[scan_idx];
            rd_idx_reg  <= scan_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
        if (cmd.start)
        begin
            req_reg <= amt_in;
        end
        if (cmd.res_load)
        begin
            if (cmd.res_alloc && found_reg)
            begin
                rsp_reg.granted      <= 1'b1;
                rsp_reg.chosen_block <= pick_ext[2:0];
                rsp_reg.left_over    <= remain_ext[15:0];
            end
            else
            begin
                rsp_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            found_reg  <= found_next;
        end
    end

    assign status.found = found_reg;
    assign rsp_item     = rsp_reg;

endmodule

>>> rtl/fpba_ctrl.sv
// Controller of the fit-policy block allocator: handshakes, scan sequencing, result valid.
`timescale 1ns / 1ps

module fpba_ctrl #(
    parameter int BLOCKS = fpba_pkg::BLOCKS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    input  logic                                    req_op,
    output logic                                    req_stall,
    output logic                                    rsp_valid,
    input  logic                                    rsp_stall,
    input  logic [3:0]                              active_blocks,
    input  fpba_pkg::fpba_status_t                  status,
    output fpba_pkg::fpba_cmd_t                     cmd,
    output logic [((BLOCKS > 1) ? $clog2(BLOCKS) : 1)-1:0] scan_idx
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CMP_W = ((IDX_W > 4) ? IDX_W : 4) + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_LAST  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    logic [3:0]       limit;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] lim_ext;
    logic             last_idx;
    logic             out_free;
    logic             accept;

    // Entries taking part: active_blocks, clipped to the table depth.
    always_comb
    begin
        if (32'(active_blocks) > BLOCKS)
        begin
            limit = 4'(BLOCKS);
        end
        else
        begin
            limit = active_blocks;
        end
    end

    assign idx_ext  = CMP_W'(idx_reg);
    assign lim_ext  = CMP_W'(limit);
    assign last_idx = (idx_ext == (lim_ext - CMP_W'(1)));
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // A load produces its result at once and needs the result register free.
    assign req_stall = (state_reg != ST_IDLE) || ((req_op == fpba_pkg::OP_LOAD) && !out_free);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    if (req_op == fpba_pkg::OP_LOAD)
                    begin
                        cmd.ld_we      = 1'b1;
                        cmd.res_load   = 1'b1;
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        if (limit == 4'd0)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (last_idx)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.wb_we      = status.found;
                    cmd.res_load   = 1'b1;
                    cmd.res_alloc  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign scan_idx  = idx_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> rtl/fpba_checker.sv
// Port-level checker of the fit-policy block allocator and its bind to the top level.
`timescale 1ns / 1ps
`include "fit_policy_block_allocator_top_defines.svh"

module fpba_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input fpba_pkg::req_item_t req_item,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input fpba_pkg::rsp_item_t rsp_item
);

    logic load_acc;
    logic alloc_acc;
    logic ungranted_ok;

    assign load_acc     = req_valid && !req_stall && (req_item.op == fpba_pkg::OP_LOAD);
    assign alloc_acc    = req_valid && !req_stall && (req_item.op == fpba_pkg::OP_ALLOC);
    assign ungranted_ok = rsp_item.granted
                          || ((rsp_item.chosen_block == 3'd0) && (rsp_item.left_over == 16'd0));

    // A result that is not granted carries zero block and zero remainder.
    `FPBA_ASSERT(a_ungranted_zero, rsp_valid |-> ungranted_ok, "ungranted result not zero")
    // A load transaction's result is presented in the next cycle and is never granted.
    `FPBA_ASSERT_NEXT(a_load_result, load_acc, rsp_valid && !rsp_item.granted, "bad load result")
    // An allocate transaction occupies the block, so the next cycle takes nothing.
    `FPBA_ASSERT_NEXT(a_alloc_busy, alloc_acc, req_stall, "transaction accepted during a search")
    // A stalled result stays presented.
    `FPBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")

endmodule

bind fit_policy_block_allocator_top fpba_checker u_fpba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);

>>> tb/sv/tb.sv
// Self-checking testbench for the fit-policy block allocator.
`timescale 1ns / 1ps

module tb;

    localparam int NUM_BLOCKS = fpba_pkg::BLOCKS_DEF;

    // The watchdog limit is counted in consecutive cycles with no transaction on any port.
    // It is set far above the slowest allocate and above any likely stall run of the receiver
    // or gap of the sender at 45 percent per cycle.
    localparam int STALL_LIMIT = 2000;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Request channel, driven by the testbench.
    logic                req_valid = 1'b0;
    logic                req_stall;
    fpba_pkg::req_item_t req_item  = '0;

    // Response channel, stalled by the testbench.
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    fpba_pkg::rsp_item_t rsp_item;

    // Register port.
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Percent chance per cycle that the sender holds off or the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int fail_count  = 0;
    int quiet_count = 0;

    // Predictor state: its own copy of the size table and of the two registers.
    logic [15:0] free_table [NUM_BLOCKS];
    logic [1:0]  fit_policy   = fpba_pkg::FIT_MODE_RST;
    logic [3:0]  active_count = fpba_pkg::ACTIVE_BLOCKS_RST;

    // Placement results predicted for accepted requests, oldest first.
    fpba_pkg::rsp_item_t predicted_placements [$];

    fit_policy_block_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // The receiver decides anew every cycle whether to stall the response channel.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Applies one request to the predicted table and returns the result it should give.
    // A load writes its slot and always reports zeros. An allocate scans the active
    // entries; first fit stops at the first entry that is large enough, best fit keeps
    // the smallest and worst fit the largest, and the strict comparisons leave ties with
    // the lower index. The unused policy code falls back to first fit.
    function automatic fpba_pkg::rsp_item_t place_request(fpba_pkg::req_item_t item);
        fpba_pkg::rsp_item_t placed;
        int                  scan_len;
        int                  pick;
        int                  i;
        bit                  hit;

        placed = '0;
        if (item.op == fpba_pkg::OP_LOAD)
        begin
            free_table[item.block_slot] = item.amount;
            return placed;
        end
        // Counts above the table size act as the whole table.
        scan_len = (active_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(active_count);
        hit      = 1'b0;
        pick     = 0;
        for (i = 0; i < scan_len; i++)
        begin
            if (free_table[i] >= item.amount)
            begin
                if (!hit)
                begin
                    hit  = 1'b1;
                    pick = i;
                    if (fit_policy != fpba_pkg::FIT_BEST && fit_policy != fpba_pkg::FIT_WORST)
                        break;
                end
                else if (fit_policy == fpba_pkg::FIT_BEST && free_table[i] < free_table[pick])
                    pick = i;
                else if (fit_policy == fpba_pkg::FIT_WORST && free_table[i] > free_table[pick])
                    pick = i;
            end
        end
        if (hit)
        begin
            free_table[pick]    = free_table[pick] - item.amount;
            placed.granted      = 1'b1;
            placed.chosen_block = pick[2:0];
            placed.left_over    = free_table[pick];
        end
        return placed;
    endfunction

    // Presents one request after a random hold-off and waits until the block takes it.
    // Valid is left high after acceptance, so back-to-back transactions never lower and
    // raise it within the same time step; the next hold-off or drain lowers it.
    task automatic send_request(input fpba_pkg::req_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted_placements.push_back(place_request(item));
    endtask

    task automatic send_fields(input logic op, input int slot, input int amount);
        fpba_pkg::req_item_t item;

        item.op         = op;
        item.block_slot = slot[2:0];
        item.amount     = amount[15:0];
        send_request(item);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_placements.size() != 0);
    endtask

    // Writes one register once the block is idle: a setup phase, then an access phase
    // that completes on the first edge with pready high.
    task automatic write_register(input logic index, input int value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == fpba_pkg::REG_FIT_MODE)
            fit_policy = value[1:0];
        else
            active_count = value[3:0];
    endtask

    // Builds a random request from the current predicted table, so that allocations
    // mostly fit, often exactly, and ties between equal entries come up regularly.
    function automatic fpba_pkg::req_item_t random_request();
        fpba_pkg::req_item_t item;
        int                  ref_size;

        item.block_slot = 3'($urandom_range(0, NUM_BLOCKS - 1));
        ref_size        = int'(free_table[$urandom_range(0, NUM_BLOCKS - 1)]);
        if ($urandom_range(0, 99) < 55)
        begin
            item.op = fpba_pkg::OP_ALLOC;
            case ($urandom_range(0, 9))
                0:       item.amount = '0;
                1:       item.amount = 16'hFFFF;
                2, 3:    item.amount = 16'($urandom);
                4, 5:    item.amount = ref_size[15:0];
                default: item.amount = 16'($urandom_range(0, ref_size));
            endcase
        end
        else
        begin
            item.op = fpba_pkg::OP_LOAD;
            case ($urandom_range(0, 9))
                0:       item.amount = '0;
                1:       item.amount = 16'hFFFF;
                2, 3:    item.amount = ref_size[15:0];
                4, 5:    item.amount = 16'($urandom_range(0, 2000));
                default: item.amount = 16'($urandom);
            endcase
        end
        return item;
    endfunction

    // Every accepted result is compared, field by field, with the oldest prediction.
    always @(posedge clk)
    begin : check_placement
        fpba_pkg::rsp_item_t want;

        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_placements.size() == 0)
            begin
                $error("result with no request pending: granted %0d block %0d left %0d",
                       rsp_item.granted, rsp_item.chosen_block, rsp_item.left_over);
                fail_count++;
            end
            else
            begin
                want = predicted_placements.pop_front();
                if (rsp_item.granted !== want.granted)
                begin
                    $error("granted: expected %0d, actual %0d", want.granted, rsp_item.granted);
                    fail_count++;
                end
                if (rsp_item.chosen_block !== want.chosen_block)
                begin
                    $error("chosen_block: expected %0d, actual %0d",
                           want.chosen_block, rsp_item.chosen_block);
                    fail_count++;
                end
                if (rsp_item.left_over !== want.left_over)
                begin
                    $error("left_over: expected %0d, actual %0d",
                           want.left_over, rsp_item.left_over);
                    fail_count++;
                end
            end
        end
    end

    // The watchdog ends a run that has stopped moving: it counts cycles in which no
    // transaction completes on either channel and no register access takes place.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Loads every slot first, since an allocate must never scan an entry that was never
    // written; from here on the whole table holds defined sizes. The values include both
    // extremes and a pair of equal sizes for the tie rules. Then allocations of the
    // largest and smallest amounts, including one that cannot be placed.
    task automatic test_table_extremes();
        send_fields(fpba_pkg::OP_LOAD, 0, 16'hFFFF);
        send_fields(fpba_pkg::OP_LOAD, 1, 0);
        send_fields(fpba_pkg::OP_LOAD, 2, 100);
        send_fields(fpba_pkg::OP_LOAD, 3, 40);
        send_fields(fpba_pkg::OP_LOAD, 4, 40);
        send_fields(fpba_pkg::OP_LOAD, 5, 300);
        send_fields(fpba_pkg::OP_LOAD, 6, 7);
        send_fields(fpba_pkg::OP_LOAD, 7, 1000);
        send_fields(fpba_pkg::OP_ALLOC, 7, 16'hFFFF);
        send_fields(fpba_pkg::OP_ALLOC, 0, 0);
        send_fields(fpba_pkg::OP_ALLOC, 5, 16'hFFFF);
    endtask

    // Runs the same pair of requests under every policy code, the unused one included.
    task automatic test_fit_policies();
        write_register(fpba_pkg::REG_FIT_MODE, int'(fpba_pkg::FIT_FIRST));
        send_fields(fpba_pkg::OP_ALLOC, 0, 30);
        send_fields(fpba_pkg::OP_ALLOC, 0, 1);
        write_register(fpba_pkg::REG_FIT_MODE, int'(fpba_pkg::FIT_BEST));
        send_fields(fpba_pkg::OP_ALLOC, 0, 30);
        send_fields(fpba_pkg::OP_ALLOC, 0, 1);
        write_register(fpba_pkg::REG_FIT_MODE, int'(fpba_pkg::FIT_WORST));
        send_fields(fpba_pkg::OP_ALLOC, 0, 30);
        send_fields(fpba_pkg::OP_ALLOC, 0, 1);
        write_register(fpba_pkg::REG_FIT_MODE, int'(fpba_pkg::FIT_RESERVED));
        send_fields(fpba_pkg::OP_ALLOC, 0, 30);
        send_fields(fpba_pkg::OP_ALLOC, 0, 1);
    endtask

    // No active blocks grants nothing, a count above the table size covers the whole
    // table, and a single active block hides every other entry.
    task automatic test_active_limits();
        write_register(fpba_pkg::REG_FIT_MODE, int'(fpba_pkg::FIT_WORST));
        write_register(fpba_pkg::REG_ACTIVE_BLOCKS, 0);
        send_fields(fpba_pkg::OP_ALLOC, 0, 0);
        write_register(fpba_pkg::REG_ACTIVE_BLOCKS, 15);
        send_fields(fpba_pkg::OP_ALLOC, 0, 5);
        write_register(fpba_pkg::REG_ACTIVE_BLOCKS, 1);
        send_fields(fpba_pkg::OP_ALLOC, 0, 1);
        send_fields(fpba_pkg::OP_ALLOC, 0, 16'hFFFF);
        write_register(fpba_pkg::REG_ACTIVE_BLOCKS, 8);
    endtask

    // Random traffic in three stretches: a slow sender against a slower receiver, then
    // the other way round, then both at full rate. The registers change every forty
    // requests, mostly keeping the whole table active.
    task automatic test_random_traffic();
        int stretch;
        int n;

        for (stretch = 0; stretch < 3; stretch++)
        begin
            send_idle_pct  = (stretch == 0) ? 33 : (stretch == 1) ? 45 : 0;
            recv_stall_pct = (stretch == 0) ? 45 : (stretch == 1) ? 33 : 0;
            for (n = 0; n < 267; n++)
            begin
                if (n % 40 == 0)
                begin
                    write_register(fpba_pkg::REG_FIT_MODE, $urandom_range(0, 3));
                    write_register(fpba_pkg::REG_ACTIVE_BLOCKS,
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 8);
                end
                send_request(random_request());
            end
        end
    endtask

    initial
    begin
        // Reset is held low from the start and released once, on a rising edge.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 33;
        recv_stall_pct = 45;
        test_table_extremes();
        test_fit_policies();
        test_active_limits();
        test_random_traffic();

        // Let every result come back, then watch a little longer for stray results.
        wait_drained();
        recv_stall_pct = 0;
        repeat (20) @(posedge clk);
        if (fail_count == 0 && predicted_placements.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/fpba_pkg.sv
rtl/fpba_dp.sv
rtl/fpba_ctrl.sv
rtl/fit_policy_block_allocator_top.sv
rtl/fpba_checker.sv
tb/sv/tb.sv
